>>> hdl/bfce_pkg.sv
// ----------------------------------------------------------------------------
// bfce_pkg
// Shared types, constants and helpers of the bit field copy engine.
// ----------------------------------------------------------------------------
`default_nettype none

package bfce_pkg;

  localparam int unsigned BufBytes = 64;
  localparam int unsigned IdxW     = $clog2(BufBytes);
  localparam int unsigned RegW     = 7;

  localparam logic [1:0] ACT_WR_SRC = 2'd0;
  localparam logic [1:0] ACT_WR_DST = 2'd1;
  localparam logic [1:0] ACT_COPY   = 2'd2;
  localparam logic [1:0] ACT_RD_DST = 2'd3;

  localparam logic REG_SRC_BYTES = 1'b0;
  localparam logic REG_DST_BYTES = 1'b1;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  typedef struct packed {
    logic [1:0] action;
    logic [5:0] index;
    logic [7:0] data;
    logic [8:0] src_offset;
    logic [8:0] dst_offset;
    logic [9:0] count;
    logic       right_align;
    logic       byte_units;
  } in_t;

  typedef struct packed {
    logic       kind;
    logic       ok;
    logic [7:0] read_data;
  } out_t;

  // per-byte control for the shift/merge datapath
  typedef struct packed {
    logic [2:0] shift;
    logic [2:0] head_bit;
    logic [2:0] tail_bit;
    logic       first;
    logic       last;
  } merge_ctl_t;

  function automatic logic [RegW-1:0] bytes_in_use(input logic [RegW-1:0] r);
    bytes_in_use = (r > RegW'(BufBytes)) ? RegW'(BufBytes) : r;
  endfunction

endpackage

`default_nettype wire

>>> hdl/bit_field_copy_engine.sv
// ----------------------------------------------------------------------------
// bit_field_copy_engine
// Source and destination byte buffers with an unaligned MSB-first bit copy.
// ----------------------------------------------------------------------------
// Byte writes produce no beat. A destination read is taken from the buffer
// at acceptance; its beat is loaded in the response state. A copy passes a
// check, a prefetch, a first-read and a run state over the N destination
// bytes the run touches (at most 64), then a response state that posts the
// status beat: one read-modify-write of the destination buffer per cycle sets
// the pace. A refused copy goes from check to response. A new item is taken
// once the previous one has posted its beat, even if that beat still waits.
`default_nettype none

module bit_field_copy_engine (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,

  input  wire logic              in_valid_i,
  output      logic              in_ready_o,
  input  wire bfce_pkg::in_t     in_data_i,

  output      logic              out_valid_o,
  input  wire logic              out_ready_i,
  output      bfce_pkg::out_t    out_data_o,

  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output      logic [31:0]       prdata,
  output      logic              pready
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_PRE   = 3'd2;
  localparam logic [2:0] S_FIRST = 3'd3;
  localparam logic [2:0] S_RUN   = 3'd4;
  localparam logic [2:0] S_RESP  = 3'd5;

  localparam int unsigned IW = bfce_pkg::IdxW;
  localparam int unsigned RW = bfce_pkg::RegW;

  logic [2:0]    state_q, state_d;
  bfce_pkg::in_t item_q;
  logic [RW-1:0] src_bytes_q, dst_bytes_q;
  logic          ok_q, ok_d;
  logic [IW-1:0] jw_q, jw_d, j1_q, j1_d, ks_q, ks_d;
  logic [2:0]    sh_q, sh_d, lo3_q, lo3_d, hi3_q, hi3_d;
  logic          first_q, first_d;
  logic [7:0]    prev_q;
  logic          out_valid_q;
  bfce_pkg::out_t out_q;

  logic          accept, load_out, last;
  logic          src_we, src_re, dst_we, dst_re;
  logic [IW-1:0] src_raddr, dst_waddr, dst_raddr;
  logic [7:0]    src_rdata, dst_rdata, dst_wdata, merged;
  bfce_pkg::merge_ctl_t ctl;

  // check arithmetic
  logic          align, fail;
  logic [12:0]   bits;
  logic [11:0]   sbit;
  logic [9:0]    slim, dlim, dbit_al, last_bit;
  logic [8:0]    dbit;
  logic [13:0]   sum_s, sum_d;
  logic [12:0]   p0;

  // ---------------------------------------------------------------- APB
  assign pready = 1'b1;

  always_comb begin
    prdata = '0;
    if (paddr[2] == bfce_pkg::REG_DST_BYTES) begin
      prdata[RW-1:0] = dst_bytes_q;
    end else begin
      prdata[RW-1:0] = src_bytes_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_bytes_q <= RW'(8);
      dst_bytes_q <= RW'(8);
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == bfce_pkg::REG_DST_BYTES) begin
        dst_bytes_q <= pwdata[RW-1:0];
      end else begin
        src_bytes_q <= pwdata[RW-1:0];
      end
    end
  end

  // ---------------------------------------------------------------- buffers
  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);
  assign last       = (jw_q == j1_q);

  assign src_we    = accept && (in_data_i.action == bfce_pkg::ACT_WR_SRC);
  assign src_re    = (state_q == S_PRE) || (state_q == S_FIRST) ||
                     ((state_q == S_RUN) && !last);
  assign src_raddr = ks_q;

  assign dst_we    = (accept && (in_data_i.action == bfce_pkg::ACT_WR_DST)) ||
                     (state_q == S_RUN);
  assign dst_waddr = (state_q == S_RUN) ? jw_q : in_data_i.index;
  assign dst_wdata = (state_q == S_RUN) ? merged : in_data_i.data;
  assign dst_re    = (accept && (in_data_i.action == bfce_pkg::ACT_RD_DST)) ||
                     (state_q == S_FIRST) || ((state_q == S_RUN) && !last);

  always_comb begin
    if (state_q == S_RUN) begin
      dst_raddr = jw_q + IW'(1);
    end else if (state_q == S_FIRST) begin
      dst_raddr = jw_q;
    end else begin
      dst_raddr = in_data_i.index;
    end
  end

  bfce_ram u_src_ram (
    .clk_i   (clk_i),
    .we_i    (src_we),
    .waddr_i (in_data_i.index),
    .wdata_i (in_data_i.data),
    .re_i    (src_re),
    .raddr_i (src_raddr),
    .rdata_o (src_rdata)
  );

  bfce_ram u_dst_ram (
    .clk_i   (clk_i),
    .we_i    (dst_we),
    .waddr_i (dst_waddr),
    .wdata_i (dst_wdata),
    .re_i    (dst_re),
    .raddr_i (dst_raddr),
    .rdata_o (dst_rdata)
  );

  assign ctl.shift    = sh_q;
  assign ctl.head_bit = lo3_q;
  assign ctl.tail_bit = hi3_q;
  assign ctl.first    = first_q;
  assign ctl.last     = last;

  bfce_merge u_merge (
    .prev_i (prev_q),
    .cur_i  (src_rdata),
    .dest_i (dst_rdata),
    .ctl_i  (ctl),
    .byte_o (merged)
  );

  // ---------------------------------------------------------------- check
  always_comb begin
    align    = item_q.right_align || item_q.byte_units;
    bits     = item_q.byte_units ? {item_q.count, 3'b000} : {3'b000, item_q.count};
    sbit     = item_q.byte_units ? {item_q.src_offset, 3'b000}
                                 : {3'b000, item_q.src_offset};
    slim     = {bfce_pkg::bytes_in_use(src_bytes_q), 3'b000};
    dlim     = {bfce_pkg::bytes_in_use(dst_bytes_q), 3'b000};
    dbit_al  = dlim - bits[9:0];
    dbit     = align ? dbit_al[8:0] : item_q.dst_offset;
    sum_s    = {2'b00, sbit} + {1'b0, bits};
    sum_d    = {5'b00000, dbit} + {1'b0, bits};
    fail     = (bits == '0) ||
               (align && (bits > {3'b000, dlim})) ||
               (sum_s > {4'b0000, slim}) ||
               (sum_d > {4'b0000, dlim});
    last_bit = {1'b0, dbit} + bits[9:0] - 10'd1;
    p0       = {1'b0, sbit} - {10'b0, dbit[2:0]};
  end

  // ---------------------------------------------------------------- control
  always_comb begin
    state_d  = state_q;
    ok_d     = ok_q;
    jw_d     = jw_q;
    j1_d     = j1_q;
    ks_d     = ks_q;
    sh_d     = sh_q;
    lo3_d    = lo3_q;
    hi3_d    = hi3_q;
    first_d  = first_q;
    load_out = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (in_data_i.action)
            bfce_pkg::ACT_COPY:   state_d = S_CHECK;
            bfce_pkg::ACT_RD_DST: state_d = S_RESP;
            default:              state_d = S_IDLE;
          endcase
        end
      end
      S_CHECK: begin
        ok_d    = !fail;
        jw_d    = dbit[8:3];
        j1_d    = last_bit[8:3];
        ks_d    = p0[8:3];
        sh_d    = p0[2:0];
        lo3_d   = dbit[2:0];
        hi3_d   = last_bit[2:0];
        first_d = 1'b1;
        state_d = fail ? S_RESP : S_PRE;
      end
      S_PRE: begin
        ks_d    = ks_q + IW'(1);
        state_d = S_FIRST;
      end
      S_FIRST: begin
        ks_d    = ks_q + IW'(1);
        state_d = S_RUN;
      end
      S_RUN: begin
        first_d = 1'b0;
        if (last) begin
          state_d = S_RESP;
        end else begin
          ks_d = ks_q + IW'(1);
          jw_d = jw_q + IW'(1);
        end
      end
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_data_i;
    end
    if ((state_q == S_FIRST) || (state_q == S_RUN)) begin
      prev_q <= src_rdata;
    end
    ok_q    <= ok_d;
    jw_q    <= jw_d;
    j1_q    <= j1_d;
    ks_q    <= ks_d;
    sh_q    <= sh_d;
    lo3_q   <= lo3_d;
    hi3_q   <= hi3_d;
    first_q <= first_d;
    if (load_out) begin
      if (item_q.action == bfce_pkg::ACT_RD_DST) begin
        out_q.kind      <= bfce_pkg::KIND_READ;
        out_q.ok        <= 1'b1;
        out_q.read_data <= dst_rdata;
      end else begin
        out_q.kind      <= bfce_pkg::KIND_STATUS;
        out_q.ok        <= ok_q;
        out_q.read_data <= 8'h00;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

>>> hdl/bfce_ram.sv
// ----------------------------------------------------------------------------
// bfce_ram
// Byte-wide buffer, one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bfce_ram (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [bfce_pkg::IdxW-1:0] waddr_i,
  input  wire logic [7:0]               wdata_i,
  input  wire logic                     re_i,
  input  wire logic [bfce_pkg::IdxW-1:0] raddr_i,
  output      logic [7:0]               rdata_o
);

  logic [7:0] mem_q [bfce_pkg::BufBytes];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> hdl/bfce_merge.sv
// ----------------------------------------------------------------------------
// bfce_merge
// Aligns a two-byte source window to one destination byte and merges it
// under the edge masks of the run.
// ----------------------------------------------------------------------------
`default_nettype none

module bfce_merge (
  input  wire logic                 [7:0] prev_i,
  input  wire logic                 [7:0] cur_i,
  input  wire logic                 [7:0] dest_i,
  input  wire bfce_pkg::merge_ctl_t       ctl_i,
  output      logic                 [7:0] byte_o
);

  logic [15:0] window;
  logic [7:0]  head_mask;
  logic [7:0]  tail_mask;
  logic [7:0]  mask;

  always_comb begin
    window    = {prev_i, cur_i} << ctl_i.shift;
    head_mask = 8'hff >> ctl_i.head_bit;
    tail_mask = 8'hff << (3'd7 - ctl_i.tail_bit);
    mask      = (ctl_i.first ? head_mask : 8'hff) & (ctl_i.last ? tail_mask : 8'hff);
    byte_o    = (dest_i & ~mask) | (window[15:8] & mask);
  end

endmodule

`default_nettype wire
